/* hdl/tmst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmst_pkg
// Shared types, command and error codes and beat layouts for the message
// slot table.
// ----------------------------------------------------------------------------
package tmst_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int CMD_W   = 4;
    localparam int ID_W    = 5;
    localparam int TAG_W   = 8;
    localparam int DATE_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int STATE_W = 3;
    localparam int ERR_W   = 2;

    // Input beat layout, lowest bit first.
    localparam int IN_CMD_LO   = 0;
    localparam int IN_ID_LO    = IN_CMD_LO + CMD_W;
    localparam int IN_TAG_LO   = IN_ID_LO + ID_W;
    localparam int IN_CDATE_LO = IN_TAG_LO + TAG_W;
    localparam int IN_ADATE_LO = IN_CDATE_LO + DATE_W;
    localparam int IN_SIZE_LO  = IN_ADATE_LO + DATE_W;
    localparam int IN_STATE_LO = IN_SIZE_LO + SIZE_W;
    localparam int IN_THR_LO   = IN_STATE_LO + STATE_W;
    localparam int IN_USED_W   = IN_THR_LO + DATE_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output beat layout, lowest bit first.
    localparam int OUT_ERR_LO   = 0;
    localparam int OUT_ID_LO    = OUT_ERR_LO + ERR_W;
    localparam int OUT_TAG_LO   = OUT_ID_LO + ID_W;
    localparam int OUT_CDATE_LO = OUT_TAG_LO + TAG_W;
    localparam int OUT_ADATE_LO = OUT_CDATE_LO + DATE_W;
    localparam int OUT_SIZE_LO  = OUT_ADATE_LO + DATE_W;
    localparam int OUT_STATE_LO = OUT_SIZE_LO + SIZE_W;
    localparam int OUT_FREE_LO  = OUT_STATE_LO + STATE_W;
    localparam int OUT_USED_W   = OUT_FREE_LO + ID_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT          = 4'd0;
    localparam logic [CMD_W-1:0] CMD_GET             = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR           = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_TAG       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_OLDEST          = 4'd5;
    localparam logic [CMD_W-1:0] CMD_YOUNGEST        = 4'd6;
    localparam logic [CMD_W-1:0] CMD_YOUNGEST_BEFORE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SET_STATUS      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SET_ACK         = 4'd9;

    localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL        = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_NONE_FILLED = 2'd3;

    localparam logic [STATE_W-1:0] STATUS_WAIT_TX = 3'd1;

    localparam logic [DATE_W-1:0] EPOCH_MAX = 32'hFFFF_FFFF;
    localparam logic [DATE_W-1:0] EPOCH_MIN = 32'h0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted beat and reset the scan
        logic rd;     // read the slot under the scan pointer
        logic emit;   // load the result register
    } tmst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_idx;  // scan pointer is on the last slot
        logic out_free;  // result register can take a new beat
    } tmst_sts_t;

endpackage
`default_nettype wire

/* hdl/tmst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmst_ctrl
// Command sequencer: accepts a beat, runs one scan over all slots, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module tmst_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tmst_pkg::tmst_sts_t sts,
    output tmst_pkg::tmst_cmd_t      cmd
);
    import tmst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.last_idx)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // The last slot read is processed in this cycle.
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/tmst_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmst_dp
// Slot storage, scan pointer, per-slot command evaluation and result
// register.
// ----------------------------------------------------------------------------
module tmst_dp #(
    parameter int NUM_SLOTS = tmst_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tmst_pkg::tmst_cmd_t                 cmd,
    output tmst_pkg::tmst_sts_t                      sts,
    input  wire logic [tmst_pkg::IN_TDATA_W-1:0]     in_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [tmst_pkg::OUT_TDATA_W-1:0]         out_data
);
    import tmst_pkg::*;

    localparam int IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW   = $clog2(NUM_SLOTS + 1);
    localparam int CMPW = (IW + 1 > ID_W) ? IW + 1 : ID_W;

    // Captured command beat.
    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [DATE_W-1:0]  cdate_reg;
    logic [DATE_W-1:0]  adate_reg;
    logic [SIZE_W-1:0]  psize_reg;
    logic [STATE_W-1:0] st_reg;
    logic [DATE_W-1:0]  thr_reg;

    // Slot storage.
    logic [TAG_W-1:0]   mem_tag     [NUM_SLOTS];
    logic [DATE_W-1:0]  mem_created [NUM_SLOTS];
    logic [DATE_W-1:0]  mem_ack     [NUM_SLOTS];
    logic [SIZE_W-1:0]  mem_size    [NUM_SLOTS];
    logic [STATE_W-1:0] mem_status  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    logic [NUM_SLOTS-1:0] ackw_reg;
    logic [NUM_SLOTS-1:0] ackw_next;

    logic [TAG_W-1:0]   rd_tag_reg;
    logic [DATE_W-1:0]  rd_created_reg;
    logic [DATE_W-1:0]  rd_ack_reg;
    logic [SIZE_W-1:0]  rd_size_reg;
    logic [STATE_W-1:0] rd_status_reg;

    // Scan pipeline.
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [IW-1:0] idx_d_reg;
    logic          pv_reg;

    // Running result.
    logic                found_reg;
    logic                found_next;
    logic [DATE_W-1:0]   best_reg;
    logic [DATE_W-1:0]   best_next;
    logic [CMPW-1:0]     res_id_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic [DATE_W-1:0]   res_created_reg;
    logic [DATE_W-1:0]   res_ack_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic [STATE_W-1:0]  res_state_reg;
    logic [CW-1:0]       free_reg;
    logic [CW-1:0]       free_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Per-slot evaluation.
    logic            slot_v;
    logic [CMPW-1:0] slot_id;
    logic            id_match;
    logic            ins_we;
    logic            st_we;
    logic            ack_we;
    logic            clr;
    logic            cap_get;
    logic            cap_search;
    logic            hit;

    logic [CMPW-1:0] free_ext;
    logic            is_search;

    assign slot_v   = valid_reg[idx_d_reg];
    assign slot_id  = CMPW'(idx_d_reg) + CMPW'(1);
    assign id_match = (slot_id == CMPW'(id_reg));

    always_comb
    begin
        ins_we     = 1'b0;
        st_we      = 1'b0;
        ack_we     = 1'b0;
        clr        = 1'b0;
        cap_get    = 1'b0;
        cap_search = 1'b0;
        hit        = 1'b0;
        if (pv_reg)
        begin
            unique case (cmd_reg) inside
                CMD_INSERT:
                begin
                    ins_we = !found_reg && !slot_v;
                end
                CMD_GET:
                begin
                    cap_get = slot_v && id_match;
                end
                CMD_CLEAR:
                begin
                    clr = slot_v && id_match;
                end
                CMD_CLEAR_TAG:
                begin
                    clr = slot_v && (rd_tag_reg == tag_reg);
                end
                CMD_CLEAR_ALL:
                begin
                    clr = slot_v;
                end
                CMD_OLDEST, CMD_YOUNGEST, CMD_YOUNGEST_BEFORE:
                begin
                    if (cmd_reg == CMD_OLDEST)
                    begin
                        hit = rd_created_reg <= best_reg;
                    end
                    else if (cmd_reg == CMD_YOUNGEST)
                    begin
                        hit = rd_created_reg >= best_reg;
                    end
                    else
                    begin
                        hit = (rd_created_reg >= best_reg) && (rd_created_reg < thr_reg);
                    end
                    cap_search = slot_v && hit;
                end
                CMD_SET_STATUS:
                begin
                    st_we = slot_v && id_match;
                end
                CMD_SET_ACK:
                begin
                    ack_we = slot_v && id_match;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control-side next values.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        ackw_next  = ackw_reg;
        found_next = found_reg;
        best_next  = best_reg;
        free_next  = free_reg;
        if (cmd.load)
        begin
            idx_next   = '0;
            found_next = 1'b0;
            best_next  = (in_data[IN_CMD_LO +: CMD_W] == CMD_OLDEST) ? EPOCH_MAX : EPOCH_MIN;
        end
        else if (cmd.rd)
        begin
            idx_next = idx_reg + IW'(1);
        end
        if (ins_we)
        begin
            valid_next[idx_d_reg] = 1'b1;
            free_next             = free_reg - CW'(1);
        end
        if (clr)
        begin
            valid_next[idx_d_reg] = 1'b0;
            free_next             = free_reg + CW'(1);
        end
        if (ack_we)
        begin
            ackw_next[idx_d_reg] = 1'b1;
        end
        if (ins_we || clr || cap_get || cap_search || st_we || ack_we)
        begin
            found_next = 1'b1;
        end
        if (cap_search)
        begin
            best_next = rd_created_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            valid_reg     <= '0;
            ackw_reg      <= '0;
            found_reg     <= 1'b0;
            free_reg      <= CW'(NUM_SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            pv_reg    <= cmd.rd;
            valid_reg <= valid_next;
            ackw_reg  <= ackw_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_data[IN_CMD_LO +: CMD_W];
            id_reg    <= in_data[IN_ID_LO +: ID_W];
            tag_reg   <= in_data[IN_TAG_LO +: TAG_W];
            cdate_reg <= in_data[IN_CDATE_LO +: DATE_W];
            adate_reg <= in_data[IN_ADATE_LO +: DATE_W];
            psize_reg <= in_data[IN_SIZE_LO +: SIZE_W];
            st_reg    <= in_data[IN_STATE_LO +: STATE_W];
            thr_reg   <= in_data[IN_THR_LO +: DATE_W];
        end
        if (cmd.rd)
        begin
            idx_d_reg <= idx_reg;
        end
        best_reg <= best_next;
        if (ins_we || cap_search)
        begin
            res_id_reg <= slot_id;
        end
        if (cap_search)
        begin
            res_created_reg <= rd_created_reg;
        end
        if (cap_get)
        begin
            res_tag_reg     <= rd_tag_reg;
            res_created_reg <= rd_created_reg;
            // An acknowledge time never written since reset reads as zero.
            res_ack_reg     <= ackw_reg[idx_d_reg] ? rd_ack_reg : '0;
            res_size_reg    <= rd_size_reg;
            res_state_reg   <= rd_status_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Slot memories: one write at the processed slot, one read at the pointer.
    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            mem_tag[idx_d_reg]     <= tag_reg;
            mem_created[idx_d_reg] <= cdate_reg;
            mem_size[idx_d_reg]    <= psize_reg;
        end
        if (ins_we || st_we)
        begin
            mem_status[idx_d_reg] <= ins_we ? STATUS_WAIT_TX : st_reg;
        end
        if (ack_we)
        begin
            mem_ack[idx_d_reg] <= adate_reg;
        end
        if (cmd.rd)
        begin
            rd_tag_reg     <= mem_tag[idx_reg];
            rd_created_reg <= mem_created[idx_reg];
            rd_ack_reg     <= mem_ack[idx_reg];
            rd_size_reg    <= mem_size[idx_reg];
            rd_status_reg  <= mem_status[idx_reg];
        end
    end

    assign free_ext  = CMPW'(free_reg);
    assign is_search = (cmd_reg == CMD_OLDEST) || (cmd_reg == CMD_YOUNGEST)
                       || (cmd_reg == CMD_YOUNGEST_BEFORE);

    always_comb
    begin
        out_data_next = '0;
        unique case (cmd_reg) inside
            CMD_INSERT:
            begin
                out_data_next[OUT_ERR_LO +: ERR_W] = found_reg ? ERR_OK : ERR_FULL;
            end
            CMD_GET, CMD_CLEAR, CMD_SET_STATUS, CMD_SET_ACK:
            begin
                out_data_next[OUT_ERR_LO +: ERR_W] = found_reg ? ERR_OK : ERR_NOT_FOUND;
            end
            CMD_OLDEST, CMD_YOUNGEST, CMD_YOUNGEST_BEFORE:
            begin
                out_data_next[OUT_ERR_LO +: ERR_W] = found_reg ? ERR_OK : ERR_NONE_FILLED;
            end
            default:
            begin
                out_data_next[OUT_ERR_LO +: ERR_W] = ERR_OK;
            end
        endcase
        if (found_reg && ((cmd_reg == CMD_INSERT) || is_search))
        begin
            out_data_next[OUT_ID_LO +: ID_W] = res_id_reg[ID_W-1:0];
        end
        if (found_reg && ((cmd_reg == CMD_GET) || (cmd_reg == CMD_YOUNGEST_BEFORE)))
        begin
            out_data_next[OUT_CDATE_LO +: DATE_W] = res_created_reg;
        end
        if (found_reg && (cmd_reg == CMD_GET))
        begin
            out_data_next[OUT_TAG_LO +: TAG_W]     = res_tag_reg;
            out_data_next[OUT_ADATE_LO +: DATE_W]  = res_ack_reg;
            out_data_next[OUT_SIZE_LO +: SIZE_W]   = res_size_reg;
            out_data_next[OUT_STATE_LO +: STATE_W] = res_state_reg;
        end
        out_data_next[OUT_FREE_LO +: ID_W] = free_ext[ID_W-1:0];
    end

    assign sts.last_idx = (idx_reg == IW'(NUM_SLOTS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule
`default_nettype wire

/* hdl/timestamped_message_slot_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_message_slot_table_top
// Table of message slots with insert, lookup, clear and age searches.
// ----------------------------------------------------------------------------
// Usage:
// One command beat enters on s_axis; one result beat leaves on m_axis for
// every command. Slot ids are the slot index plus one; id 0 names no slot.
// Every command is carried out by one pass over all NUM_SLOTS slots, reading
// one slot per cycle from the slot memories and updating it in the cycle
// after, so one shared compare unit serves all searches.
// After a command beat is accepted, the scan reads every slot, a flush step
// processes the last slot read, and the result is then loaded into the
// output register once it is free. A new command is taken only after that
// load; s_axis_tready is high only while no command is in flight.
// A finished result waits in the output register while m_axis_tready is low;
// the next command is still accepted and runs, and its result is loaded once
// the waiting beat has gone.
// Reset empties every slot and sets every acknowledge time to zero at once;
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module timestamped_message_slot_table_top #(
    parameter int NUM_SLOTS = tmst_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // command, slot_id, tag, created_date, ack_date, payload_size,
    // slot_state, threshold
    input  wire logic [tmst_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // error_code, out_slot_id, out_tag, out_created_date, out_ack_date,
    // out_payload_size, out_slot_state, free_count
    output logic [tmst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import tmst_pkg::*;

    tmst_cmd_t cmd;
    tmst_sts_t sts;

    tmst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmst_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    // Only one command is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while another is in flight");

    // A loaded result is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("result register load not followed by a valid beat");

    // A failed search reports no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[OUT_ERR_LO +: ERR_W] == ERR_NONE_FILLED)
        |-> (m_axis_tdata[OUT_ID_LO +: ID_W] == '0))
        else $error("failed search reports a slot id");

    // A failed insert means the table is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[OUT_ERR_LO +: ERR_W] == ERR_FULL)
        |-> (m_axis_tdata[OUT_FREE_LO +: ID_W] == '0))
        else $error("insert failed with free slots left");

endmodule
`default_nettype wire

/* tb/slot_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker
// Watches the command and result streams of the message slot table, keeps
// its own copy of the slot table, works out the result of every accepted
// command and compares each result beat field by field with it.
// ----------------------------------------------------------------------------
module slot_table_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [tmst_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [tmst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                                   mismatch_count,
    output int                                   pending_results
);
    import tmst_pkg::*;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [ID_W-1:0]    id;
        logic [TAG_W-1:0]   tag;
        logic [DATE_W-1:0]  cdate;
        logic [DATE_W-1:0]  adate;
        logic [SIZE_W-1:0]  nbytes;
        logic [STATE_W-1:0] status;
        logic [ID_W-1:0]    free;
    } slot_result_t;

    logic               slot_used    [NUM_SLOTS];
    logic [TAG_W-1:0]   slot_tag     [NUM_SLOTS];
    logic [DATE_W-1:0]  slot_created [NUM_SLOTS];
    logic [DATE_W-1:0]  slot_acked   [NUM_SLOTS];
    logic [SIZE_W-1:0]  slot_nbytes  [NUM_SLOTS];
    logic [STATE_W-1:0] slot_status  [NUM_SLOTS];

    slot_result_t expected_results[$];
    slot_result_t want;
    slot_result_t got;

    // The acknowledge time survives every kind of clear.
    function automatic void vacate(int i);
        slot_used[i]    = 1'b0;
        slot_tag[i]     = '0;
        slot_created[i] = '0;
        slot_nbytes[i]  = '0;
        slot_status[i]  = '0;
    endfunction

    function automatic int filled_index(logic [ID_W-1:0] id);
        if (id == '0 || int'(id) > NUM_SLOTS)
            return -1;
        if (!slot_used[int'(id) - 1])
            return -1;
        return int'(id) - 1;
    endfunction

    function automatic logic [ID_W-1:0] empty_count();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_used[i])
                n++;
        return ID_W'(n);
    endfunction

    function automatic slot_result_t execute_command(logic [IN_TDATA_W-1:0] beat);
        slot_result_t       r;
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [TAG_W-1:0]   tag;
        logic [DATE_W-1:0]  cdate;
        logic [DATE_W-1:0]  adate;
        logic [SIZE_W-1:0]  nbytes;
        logic [STATE_W-1:0] status;
        logic [DATE_W-1:0]  thr;
        logic [DATE_W-1:0]  best;
        logic               placed;
        logic               hit;
        int                 k;
        int                 found;
        r      = '0;
        cmd    = beat[IN_CMD_LO +: CMD_W];
        id     = beat[IN_ID_LO +: ID_W];
        tag    = beat[IN_TAG_LO +: TAG_W];
        cdate  = beat[IN_CDATE_LO +: DATE_W];
        adate  = beat[IN_ADATE_LO +: DATE_W];
        nbytes = beat[IN_SIZE_LO +: SIZE_W];
        status = beat[IN_STATE_LO +: STATE_W];
        thr    = beat[IN_THR_LO +: DATE_W];
        k      = filled_index(id);
        case (cmd)
            CMD_INSERT:
            begin
                r.err  = ERR_FULL;
                placed = 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!placed && !slot_used[i])
                    begin
                        slot_used[i]    = 1'b1;
                        slot_tag[i]     = tag;
                        slot_created[i] = cdate;
                        slot_nbytes[i]  = nbytes;
                        slot_status[i]  = STATUS_WAIT_TX;
                        r.err           = ERR_OK;
                        r.id            = ID_W'(i + 1);
                        placed          = 1'b1;
                    end
                end
            end
            CMD_GET:
            begin
                if (k < 0)
                    r.err = ERR_NOT_FOUND;
                else
                begin
                    r.tag    = slot_tag[k];
                    r.cdate  = slot_created[k];
                    r.adate  = slot_acked[k];
                    r.nbytes = slot_nbytes[k];
                    r.status = slot_status[k];
                end
            end
            CMD_CLEAR:
            begin
                if (k < 0)
                    r.err = ERR_NOT_FOUND;
                else
                    vacate(k);
            end
            CMD_CLEAR_TAG:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_used[i] && slot_tag[i] == tag)
                        vacate(i);
            end
            CMD_CLEAR_ALL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    vacate(i);
            end
            CMD_OLDEST, CMD_YOUNGEST, CMD_YOUNGEST_BEFORE:
            begin
                // Ties go to the later slot, hence the inclusive compares.
                best  = (cmd == CMD_OLDEST) ? EPOCH_MAX : EPOCH_MIN;
                found = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (cmd == CMD_OLDEST)
                        hit = slot_created[i] <= best;
                    else if (cmd == CMD_YOUNGEST)
                        hit = slot_created[i] >= best;
                    else
                        hit = slot_created[i] >= best && slot_created[i] < thr;
                    if (slot_used[i] && hit)
                    begin
                        best  = slot_created[i];
                        found = i + 1;
                    end
                end
                if (found == 0)
                    r.err = ERR_NONE_FILLED;
                else
                begin
                    r.id = ID_W'(found);
                    if (cmd == CMD_YOUNGEST_BEFORE)
                        r.cdate = best;
                end
            end
            CMD_SET_STATUS:
            begin
                if (k < 0)
                    r.err = ERR_NOT_FOUND;
                else
                    slot_status[k] = status;
            end
            CMD_SET_ACK:
            begin
                if (k < 0)
                    r.err = ERR_NOT_FOUND;
                else
                    slot_acked[k] = adate;
            end
            default:
            begin
            end
        endcase
        r.free = empty_count();
        return r;
    endfunction

    function automatic slot_result_t unpack_result(logic [OUT_TDATA_W-1:0] d);
        slot_result_t r;
        r.err    = d[OUT_ERR_LO +: ERR_W];
        r.id     = d[OUT_ID_LO +: ID_W];
        r.tag    = d[OUT_TAG_LO +: TAG_W];
        r.cdate  = d[OUT_CDATE_LO +: DATE_W];
        r.adate  = d[OUT_ADATE_LO +: DATE_W];
        r.nbytes = d[OUT_SIZE_LO +: SIZE_W];
        r.status = d[OUT_STATE_LO +: STATE_W];
        r.free   = d[OUT_FREE_LO +: ID_W];
        return r;
    endfunction

    task automatic check_field(string field, logic [DATE_W-1:0] exp_v, logic [DATE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: result field %s mismatch: expected 0x%0h, got 0x%0h",
                         $realtime, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                vacate(i);
                slot_acked[i] = '0;
            end
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            // A result beat always belongs to an earlier command, so it is
            // retired before the command beat of the same edge is queued.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = unpack_result(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result beat with no command outstanding: 0x%0h",
                                 $realtime, m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("error_code", DATE_W'(want.err), DATE_W'(got.err));
                    check_field("out_slot_id", DATE_W'(want.id), DATE_W'(got.id));
                    check_field("out_tag", DATE_W'(want.tag), DATE_W'(got.tag));
                    check_field("out_created_date", want.cdate, got.cdate);
                    check_field("out_ack_date", want.adate, got.adate);
                    check_field("out_payload_size", DATE_W'(want.nbytes),
                                DATE_W'(got.nbytes));
                    check_field("out_slot_state", DATE_W'(want.status),
                                DATE_W'(got.status));
                    check_field("free_count", DATE_W'(want.free), DATE_W'(got.free));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(execute_command(s_axis_tdata));
            pending_results <= expected_results.size();
        end
    end

endmodule

/* tb/timestamped_message_slot_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_message_slot_table_top_tb
// Drives the message slot table with a directed set of commands covering the
// edge cases, then with phases of random commands that fill and drain the
// table, with random gaps on both streams but in one quiet phase. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module timestamped_message_slot_table_top_tb;
    import tmst_pkg::*;

    localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 108;
    localparam int DRAIN_WAIT  = NUM_SLOTS + 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int   mismatch_count;
    int   pending_results;
    int   cycles = 0;
    logic quiet = 1'b0;
    int   insert_bias [PHASES] = '{60, 25, 70, 20, 45, 35};

    always #1 clk = ~clk;

    timestamped_message_slot_table_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    slot_table_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: a random stall before each beat, none while quiet.
    initial
    begin
        int stall;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_command(
        logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
        logic [DATE_W-1:0] cdate, logic [DATE_W-1:0] adate,
        logic [SIZE_W-1:0] nbytes, logic [STATE_W-1:0] status,
        logic [DATE_W-1:0] thr);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[IN_CMD_LO +: CMD_W]     = cmd;
        beat[IN_ID_LO +: ID_W]       = id;
        beat[IN_TAG_LO +: TAG_W]     = tag;
        beat[IN_CDATE_LO +: DATE_W]  = cdate;
        beat[IN_ADATE_LO +: DATE_W]  = adate;
        beat[IN_SIZE_LO +: SIZE_W]   = nbytes;
        beat[IN_STATE_LO +: STATE_W] = status;
        beat[IN_THR_LO +: DATE_W]    = thr;
        return beat;
    endfunction

    // Valid stays high across back-to-back beats; this task lowers it only when a
    // gap is drawn, so it never sees two assignments in one step.
    task automatic send_command(logic [IN_TDATA_W-1:0] beat);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                         logic [TAG_W-1:0] tag, logic [DATE_W-1:0] cdate,
                         logic [DATE_W-1:0] adate, logic [SIZE_W-1:0] nbytes,
                         logic [STATE_W-1:0] status, logic [DATE_W-1:0] thr);
        send_command(pack_command(cmd, id, tag, cdate, adate, nbytes, status, thr));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    function automatic logic [DATE_W-1:0] random_date();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return DATE_W'($urandom_range(0, 7));
        else if (pick == 4)
            return EPOCH_MAX;
        else if (pick == 5)
            return EPOCH_MIN;
        return $urandom;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_command(int bias);
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < bias)
            cmd = CMD_INSERT;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                cmd = CMD_GET;
            else if (pick < 32)
                cmd = CMD_CLEAR;
            else if (pick < 37)
                cmd = CMD_CLEAR_TAG;
            else if (pick < 39)
                cmd = CMD_CLEAR_ALL;
            else if (pick < 47)
                cmd = CMD_OLDEST;
            else if (pick < 55)
                cmd = CMD_YOUNGEST;
            else if (pick < 65)
                cmd = CMD_YOUNGEST_BEFORE;
            else if (pick < 78)
                cmd = CMD_SET_STATUS;
            else if (pick < 95)
                cmd = CMD_SET_ACK;
            else
                cmd = CMD_W'($urandom_range(int'(CMD_SET_ACK) + 1, (1 << CMD_W) - 1));
        end
        pick = $urandom_range(0, 19);
        if (pick < 17)
            id = ID_W'($urandom_range(1, NUM_SLOTS));
        else if (pick == 17)
            id = '0;
        else
            id = ID_W'($urandom_range(NUM_SLOTS + 1, (1 << ID_W) - 1));
        // A few tags repeat often so that clearing by tag finds matches.
        if ($urandom_range(0, 1) == 0)
            tag = TAG_W'($urandom_range(0, 3)) * 8'h55;
        else
            tag = TAG_W'($urandom);
        return pack_command(cmd, id, tag, random_date(), random_date(),
                            SIZE_W'($urandom), STATE_W'($urandom), random_date());
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then three slots with the extreme times and a tie.
        issue(CMD_OLDEST, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_GET, 1, 0, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_INSERT, 0, 8'hFF, EPOCH_MAX, EPOCH_MIN, 16'hFFFF, 0, EPOCH_MIN);
        issue(CMD_INSERT, '1, 8'h00, EPOCH_MIN, EPOCH_MAX, 16'h0000, '1, EPOCH_MAX);
        issue(CMD_INSERT, 0, 8'hFF, EPOCH_MAX, 0, 16'h1234, 0, 0);
        issue(CMD_OLDEST, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_YOUNGEST, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_YOUNGEST_BEFORE, 0, 0, 0, 0, 0, 0, EPOCH_MAX);
        issue(CMD_YOUNGEST_BEFORE, 0, 0, 0, 0, 0, 0, EPOCH_MIN);
        issue(CMD_SET_ACK, 1, 0, 0, EPOCH_MAX, 0, 0, 0);
        // Status zero keeps the slot filled.
        issue(CMD_SET_STATUS, 1, 0, 0, 0, 0, 0, 0);
        issue(CMD_GET, 1, 0, 0, 0, 0, 0, 0);
        issue(CMD_SET_STATUS, 3, 0, 0, 0, 0, '1, 0);
        issue(CMD_SET_STATUS, 0, 0, 0, 0, 0, '1, 0);
        issue(CMD_SET_ACK, ID_W'(NUM_SLOTS + 1), 0, 0, EPOCH_MAX, 0, 0, 0);
        issue(CMD_GET, '1, 0, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR, 1, 0, 0, 0, 0, 0, 0);
        issue(CMD_GET, 1, 0, 0, 0, 0, 0, 0);
        // The new occupant of slot 1 still shows the old acknowledge time.
        issue(CMD_INSERT, 0, 8'h5A, 32'h8000_0000, 0, 16'h00FF, 0, 0);
        issue(CMD_GET, 1, 0, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR_TAG, 0, 8'hFF, 0, 0, 0, 0, 0);
        issue(CMD_SET_ACK + 4'd1, '1, '1, EPOCH_MAX, EPOCH_MAX, '1, '1, EPOCH_MAX);
        issue('1, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            // Hold off until the block has answered everything so far.
            s_axis_tvalid <= 1'b0;
            wait_drained();
            quiet = (p == 2);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_command(random_command(insert_bias[p]));
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tmst_pkg.sv
hdl/tmst_ctrl.sv
hdl/tmst_dp.sv
hdl/timestamped_message_slot_table_top.sv
tb/slot_table_checker.sv
tb/timestamped_message_slot_table_top_tb.sv
